[rtl/core/owik_pkg.sv]
// Shared constants for the three-wheel omni inverse kinematics block.
// Holds CORDIC constants, the arctangent table and queue depths.
// No dependencies.
package owik_pkg;

   // CORDIC datapath: Q2.30 vectors, 32-bit binary angle
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 32;
   localparam int TRIG_W       = 18;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [CORDIC_W-1:0] HALF_LSB_Q15    = 32'sd16384;
   localparam logic signed [TRIG_W-1:0]   SQRT3_Q15       = 18'sd56756;

   // Queue depths between and after the stages
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 32;

   // atan(2^-step) in 32-bit binary angle units
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
      logic signed [CORDIC_W-1:0] val;
      case (step)
         0:       val = 32'sd536870912;
         1:       val = 32'sd316933406;
         2:       val = 32'sd167458907;
         3:       val = 32'sd85004756;
         4:       val = 32'sd42667331;
         5:       val = 32'sd21354465;
         6:       val = 32'sd10679838;
         7:       val = 32'sd5340245;
         8:       val = 32'sd2670163;
         9:       val = 32'sd1335087;
         10:      val = 32'sd667544;
         11:      val = 32'sd333772;
         12:      val = 32'sd166886;
         13:      val = 32'sd83443;
         14:      val = 32'sd41722;
         15:      val = 32'sd20861;
         16:      val = 32'sd10430;
         17:      val = 32'sd5215;
         18:      val = 32'sd2608;
         19:      val = 32'sd1304;
         20:      val = 32'sd652;
         21:      val = 32'sd326;
         22:      val = 32'sd163;
         23:      val = 32'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/core/owik_queue.sv]
// Small synchronous FIFO with a combinational head read.
// Used between front and back and as the result buffer. No package use.
module owik_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/core/owik_front.sv]
// Front end: takes command transactions and folds the heading into a
// signed half-turn angle plus a flip flag. Uses owik_pkg constants.
module owik_front #(
   parameter int SPEED_BITS = 16,
   parameter int ANGLE_BITS = 16,
   parameter int ENTRY_W    = 2 * SPEED_BITS + owik_pkg::CORDIC_W + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [SPEED_BITS-1:0] req_speed,
   input  logic [ANGLE_BITS-1:0]        req_heading_angle,
   input  logic signed [SPEED_BITS-1:0] req_spin_rate,
   output logic                         mid_push,
   output logic [ENTRY_W-1:0]           mid_data,
   input  logic                         mid_full
);

   localparam int ZW = owik_pkg::CORDIC_W;

   logic               valid_ff, valid_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [ZW-1:0]      ang32;
   logic [ZW-1:0]      z_fold;
   logic               flip;
   logic               load;

   // scale to a full-width binary angle and fold into [-1/4, 1/4) turn
   always_comb begin
      ang32    = {req_heading_angle, {(ZW - ANGLE_BITS){1'b0}}};
      flip     = ang32[ZW-1] ^ ang32[ZW-2];
      z_fold   = flip ? {~ang32[ZW-1], ang32[ZW-2:0]} : ang32;
      entry_in = {flip, z_fold, req_spin_rate, req_speed};
   end

   // one register stage; holds while the middle queue is full
   assign load     = ~valid_ff | ~mid_full;
   assign req_full = ~load;
   assign valid_in = load ? req_push : valid_ff;
   assign mid_push = valid_ff;
   assign mid_data = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_push) begin
         entry_ff <= entry_in;
      end
   end

endmodule

[rtl/core/owik_back.sv]
// Back end: 24-stage CORDIC sine/cosine, then speed scaling, sqrt(3)
// term and wheel sums. Uses owik_pkg constants and the atan table.
module owik_back #(
   parameter int SPEED_BITS = 16,
   parameter int ENTRY_W    = 2 * SPEED_BITS + owik_pkg::CORDIC_W + 1,
   parameter int OUT_BITS   = SPEED_BITS + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mid_empty,
   input  logic [ENTRY_W-1:0]         mid_data,
   output logic                       mid_pop,
   input  logic                       out_taken,
   output logic                       res_valid,
   output logic signed [OUT_BITS-1:0] res_a,
   output logic signed [OUT_BITS-1:0] res_b,
   output logic signed [OUT_BITS-1:0] res_c
);

   localparam int STEPS = owik_pkg::CORDIC_STEPS;
   localparam int XW    = owik_pkg::CORDIC_W;
   localparam int TW    = owik_pkg::TRIG_W;
   localparam int SW    = SPEED_BITS;
   localparam int PW    = SW + TW;
   localparam int VW    = PW - 15;
   localparam int KW    = VW + TW;
   localparam int SUMW  = KW - 15;
   localparam int CRW   = $clog2(owik_pkg::OUT_DEPTH + 1);

   // issue control: credits cover the pipeline plus the result buffer
   logic [CRW-1:0] credit_ff, credit_in;
   logic           issue;

   assign issue   = ~mid_empty & (credit_ff < CRW'(owik_pkg::OUT_DEPTH));
   assign mid_pop = issue;

   always_comb begin
      credit_in = credit_ff;
      if (issue && !out_taken) begin
         credit_in = credit_ff + 1'b1;
      end else if (out_taken && !issue) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // unpack the issued entry
   logic signed [SW-1:0] iss_speed, iss_spin;
   logic signed [XW-1:0] iss_z;
   logic                 iss_flip;

   assign iss_speed = mid_data[SW-1:0];
   assign iss_spin  = mid_data[2*SW-1:SW];
   assign iss_z     = mid_data[2*SW+XW-1:2*SW];
   assign iss_flip  = mid_data[2*SW+XW];

   // CORDIC rotation stages, one step per stage
   logic signed [XW-1:0] cx_ff [STEPS];
   logic signed [XW-1:0] cy_ff [STEPS];
   logic signed [XW-1:0] cz_ff [STEPS];
   logic signed [XW-1:0] cx_in [STEPS];
   logic signed [XW-1:0] cy_in [STEPS];
   logic signed [XW-1:0] cz_in [STEPS];
   logic signed [SW-1:0] csp_ff [STEPS];
   logic signed [SW-1:0] csn_ff [STEPS];
   logic                 cfl_ff [STEPS];
   logic                 cv_ff  [STEPS];

   always_comb begin
      logic signed [XW-1:0] xs, ys, zs;
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            xs = owik_pkg::CORDIC_GAIN_Q30;
            ys = '0;
            zs = iss_z;
         end else begin
            xs = cx_ff[i-1];
            ys = cy_ff[i-1];
            zs = cz_ff[i-1];
         end
         if (!zs[XW-1]) begin
            cx_in[i] = xs - (ys >>> i);
            cy_in[i] = ys + (xs >>> i);
            cz_in[i] = zs - owik_pkg::atan_turn(i);
         end else begin
            cx_in[i] = xs + (ys >>> i);
            cy_in[i] = ys - (xs >>> i);
            cz_in[i] = zs + owik_pkg::atan_turn(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEPS; i++) begin
            cv_ff[i] <= 1'b0;
         end
      end else begin
         cv_ff[0] <= issue;
         for (int i = 1; i < STEPS; i++) begin
            cv_ff[i] <= cv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STEPS; i++) begin
         cx_ff[i] <= cx_in[i];
         cy_ff[i] <= cy_in[i];
         cz_ff[i] <= cz_in[i];
      end
      csp_ff[0] <= iss_speed;
      csn_ff[0] <= iss_spin;
      cfl_ff[0] <= iss_flip;
      for (int i = 1; i < STEPS; i++) begin
         csp_ff[i] <= csp_ff[i-1];
         csn_ff[i] <= csn_ff[i-1];
         cfl_ff[i] <= cfl_ff[i-1];
      end
   end

   // round to Q1.15 and undo the half-turn fold
   logic signed [XW-1:0] x_rnd, y_rnd;
   logic signed [TW-1:0] cos_raw, sin_raw;
   logic signed [TW-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [SW-1:0] r_speed_ff, r_spin_ff;
   logic                 r_v_ff;

   always_comb begin
      x_rnd   = cx_ff[STEPS-1] + owik_pkg::HALF_LSB_Q15;
      y_rnd   = cy_ff[STEPS-1] + owik_pkg::HALF_LSB_Q15;
      cos_raw = {x_rnd[XW-1], x_rnd[XW-1:15]};
      sin_raw = {y_rnd[XW-1], y_rnd[XW-1:15]};
      cos_in  = cfl_ff[STEPS-1] ? -cos_raw : cos_raw;
      sin_in  = cfl_ff[STEPS-1] ? -sin_raw : sin_raw;
   end

   // speed times sine and cosine
   logic signed [PW-1:0] ps_ff, ps_in, pc_ff, pc_in;
   logic signed [SW-1:0] m1_spin_ff;
   logic                 m1_v_ff;

   assign ps_in = PW'(r_speed_ff) * PW'(sin_ff);
   assign pc_in = PW'(r_speed_ff) * PW'(cos_ff);

   // round products to Q7.8
   logic signed [PW-1:0] ps_rnd, pc_rnd;
   logic signed [VW-1:0] vsin_ff, vsin_in, vcos_ff, vcos_in;
   logic signed [SW-1:0] m2_spin_ff;
   logic                 m2_v_ff;

   always_comb begin
      ps_rnd  = ps_ff + PW'(owik_pkg::HALF_LSB_Q15);
      pc_rnd  = pc_ff + PW'(owik_pkg::HALF_LSB_Q15);
      vsin_in = ps_rnd[PW-1:15];
      vcos_in = pc_rnd[PW-1:15];
   end

   // sqrt(3) times vcos
   logic signed [KW-1:0] kp_ff, kp_in;
   logic signed [VW-1:0] m3_vsin_ff;
   logic signed [SW-1:0] m3_spin_ff;
   logic                 m3_v_ff;

   assign kp_in = KW'(owik_pkg::SQRT3_Q15) * KW'(vcos_ff);

   // final rounding and wheel sums, written to the result buffer
   logic signed [KW-1:0]   kp_rnd;
   logic signed [SUMW-1:0] k_val, spin_x, vsin_x, sum_a, sum_b, sum_c;

   always_comb begin
      kp_rnd = kp_ff + KW'(owik_pkg::HALF_LSB_Q15);
      k_val  = kp_rnd[KW-1:15];
      spin_x = SUMW'(m3_spin_ff);
      vsin_x = SUMW'(m3_vsin_ff);
      sum_a  = spin_x + (vsin_x <<< 1);
      sum_b  = spin_x + k_val - vsin_x;
      sum_c  = spin_x - k_val - vsin_x;
   end

   assign res_valid = m3_v_ff;
   assign res_a     = sum_a[OUT_BITS-1:0];
   assign res_b     = sum_b[OUT_BITS-1:0];
   assign res_c     = sum_c[OUT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff  <= 1'b0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else begin
         r_v_ff  <= cv_ff[STEPS-1];
         m1_v_ff <= r_v_ff;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff     <= cos_in;
      sin_ff     <= sin_in;
      r_speed_ff <= csp_ff[STEPS-1];
      r_spin_ff  <= csn_ff[STEPS-1];
      ps_ff      <= ps_in;
      pc_ff      <= pc_in;
      m1_spin_ff <= r_spin_ff;
      vsin_ff    <= vsin_in;
      vcos_ff    <= vcos_in;
      m2_spin_ff <= m1_spin_ff;
      kp_ff      <= kp_in;
      m3_vsin_ff <= vsin_ff;
      m3_spin_ff <= m2_spin_ff;
   end

endmodule

[rtl/core/omni_wheel_inverse_kinematics.sv]
// Top level of the three-wheel omni inverse kinematics block.
// Depends on owik_pkg, owik_front, owik_queue and owik_back.
//
// Usage:
//   Command channel (req_*): a transaction is taken on a rising edge with
//   req_push high and req_full low. Fields: speed (signed Q7.8), heading
//   angle (binary angle, one full turn = 2^ANGLE_BITS), spin rate (Q7.8).
//   Result channel (rsp_*): while rsp_empty is low the oldest result, three
//   signed Q9.8 wheel commands, is on the rsp_ ports; it is taken on a
//   rising edge with rsp_pop high.
//   Path with empty queues: one front stage, the middle queue, 24 CORDIC
//   steps, then round, speed multiply, product rounding, sqrt(3) multiply
//   and the wheel sums into the result buffer.
//   Throughput: one transaction per cycle unless issue credits run out,
//   set by the one-step-per-stage CORDIC pipeline and multiplier stages.
//   Stall: a 32-entry result buffer and issue credits keep the pipeline
//   from overrunning it; when the consumer stalls, issue stops, the
//   4-entry middle queue fills and req_full rises.
//   Reset (synchronous, active high) empties all queues and the pipeline;
//   there is no clearing pass.
module omni_wheel_inverse_kinematics #(
   parameter int SPEED_BITS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [SPEED_BITS-1:0] req_speed,
   input  logic [ANGLE_BITS-1:0]        req_heading_angle,
   input  logic signed [SPEED_BITS-1:0] req_spin_rate,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [SPEED_BITS+1:0] rsp_wheel_a_command,
   output logic signed [SPEED_BITS+1:0] rsp_wheel_b_command,
   output logic signed [SPEED_BITS+1:0] rsp_wheel_c_command
);

   localparam int ENTRY_W  = 2 * SPEED_BITS + owik_pkg::CORDIC_W + 1;
   localparam int OUT_BITS = SPEED_BITS + 2;
   localparam int RES_W    = 3 * OUT_BITS;

   logic               mid_push, mid_full, mid_pop, mid_empty;
   logic [ENTRY_W-1:0] mid_wr, mid_rd;
   logic               res_valid, out_full, out_taken;
   logic signed [OUT_BITS-1:0] res_a, res_b, res_c;
   logic [RES_W-1:0]   out_rd;

   // front: accept and fold the heading
   owik_front #(
      .SPEED_BITS (SPEED_BITS),
      .ANGLE_BITS (ANGLE_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_speed         (req_speed),
      .req_heading_angle (req_heading_angle),
      .req_spin_rate     (req_spin_rate),
      .mid_push          (mid_push),
      .mid_data          (mid_wr),
      .mid_full          (mid_full)
   );

   // queue between front and back
   owik_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (owik_pkg::MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wr),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   // back: trig pipeline and wheel math
   owik_back #(
      .SPEED_BITS (SPEED_BITS),
      .ENTRY_W    (ENTRY_W),
      .OUT_BITS   (OUT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rd),
      .mid_pop   (mid_pop),
      .out_taken (out_taken),
      .res_valid (res_valid),
      .res_a     (res_a),
      .res_b     (res_b),
      .res_c     (res_c)
   );

   // result buffer
   assign out_taken = rsp_pop & ~rsp_empty;

   owik_queue #(
      .WIDTH (RES_W),
      .DEPTH (owik_pkg::OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_valid),
      .wr_data ({res_c, res_b, res_a}),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_rd),
      .empty   (rsp_empty)
   );

   assign rsp_wheel_a_command = out_rd[OUT_BITS-1:0];
   assign rsp_wheel_b_command = out_rd[2*OUT_BITS-1:OUT_BITS];
   assign rsp_wheel_c_command = out_rd[3*OUT_BITS-1:2*OUT_BITS];

   // credits must keep the result buffer from being written while full
   a_no_out_overrun: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && out_full))
      else $error("result written into a full buffer");

   // the back only issues when the middle queue holds an entry
   a_issue_has_data: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("issue from an empty middle queue");

   // after reset both channels come up idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("channels not idle after reset");

endmodule
